### rtl/qabd_pkg.sv
// ----------------------------------------------------------------------------
// qabd_pkg
// Shared types and constants of the quantized anchor box decoder.
// ----------------------------------------------------------------------------
package qabd_pkg;

  // configuration of the detection head
  localparam int ClassCount  = 80;
  localparam int AnchorCount = 3;

  // field widths
  localparam int ValW      = 8;
  localparam int ChW       = 7;
  localparam int CoordW    = 8;
  localparam int AnchorW   = 2;
  localparam int BoxW      = 24;
  localparam int ScoreW    = 32;
  localparam int ClassW    = 7;
  localparam int ScaleW    = 24;
  localparam int StrideW   = 11;
  localparam int AnchorPxW = 16;
  localparam int PackW     = 3 * AnchorPxW;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = PackW;

  // channel layout of one cell
  localparam int ConfChannel = 4;
  localparam int FirstClass  = 5;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgZeroPoint     = 3'd0,
    CfgScale         = 3'd1,
    CfgConfThreshold = 3'd2,
    CfgStride        = 3'd3,
    CfgAnchorWidths  = 3'd4,
    CfgAnchorHeights = 3'd5
  } cfg_idx_e;

  // one input beat
  typedef struct packed {
    logic [AnchorW-1:0]     anchor;
    logic [CoordW-1:0]      row;
    logic [CoordW-1:0]      col;
    logic [ChW-1:0]         channel;
    logic signed [ValW-1:0] element_value;
  } elem_t;

  // one detection beat
  typedef struct packed {
    logic signed [BoxW-1:0]   box_left;
    logic signed [BoxW-1:0]   box_top;
    logic signed [BoxW-1:0]   box_width;
    logic signed [BoxW-1:0]   box_height;
    logic [ClassW-1:0]        class_id;
    logic signed [ScoreW-1:0] score;
  } det_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic deq;
    logic prep;
    logic mul;
    logic prod;
    logic sum;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
  } stat_t;

endpackage

### rtl/qabd_stream_if.sv
// ----------------------------------------------------------------------------
// qabd_stream_if
// Valid/ready channels of the decoder: element input and detection output.
// ----------------------------------------------------------------------------
interface qabd_elem_if;
  logic               valid;
  logic               ready;
  qabd_pkg::elem_t    data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface qabd_det_if;
  logic               valid;
  logic               ready;
  qabd_pkg::det_t     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/qabd_ctrl.sv
// ----------------------------------------------------------------------------
// qabd_ctrl
// Sequencer: accepts elements, steps the decode stages, owns the output valid.
// ----------------------------------------------------------------------------
module qabd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  qabd_pkg::stat_t stat_i,
  output qabd_pkg::cmd_t  cmd_o
);
  import qabd_pkg::*;

  typedef enum logic [6:0] {
    StIdle = 7'b0000001,
    StDeq  = 7'b0000010,
    StPrep = 7'b0000100,
    StMul  = 7'b0001000,
    StProd = 7'b0010000,
    StSum  = 7'b0100000,
    StOut  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   take;
  logic   load_out;

  assign in_ready_o  = (state_q == StIdle);
  assign take        = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;

  // output slot is free when empty or drained this cycle
  assign load_out = (state_q == StOut) & (~out_valid_q | out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (take && stat_i.hit) state_d = StDeq;
      StDeq:  state_d = StPrep;
      StPrep: state_d = StMul;
      StMul:  state_d = StProd;
      StProd: state_d = StSum;
      StSum:  state_d = StOut;
      StOut:  if (load_out) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // output beat valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (load_out) out_valid_d = 1'b1;
  end

  // commands
  always_comb begin
    cmd_o.take     = take;
    cmd_o.deq      = (state_q == StDeq);
    cmd_o.prep     = (state_q == StPrep);
    cmd_o.mul      = (state_q == StMul);
    cmd_o.prod     = (state_q == StProd);
    cmd_o.sum      = (state_q == StSum);
    cmd_o.load_out = load_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### rtl/qabd_dp.sv
// ----------------------------------------------------------------------------
// qabd_dp
// Datapath: configuration registers, cell capture with class argmax, and the
// staged fixed point box and score decode.
// ----------------------------------------------------------------------------
module qabd_dp #(
  parameter int ClassCount  = qabd_pkg::ClassCount,
  parameter int AnchorCount = qabd_pkg::AnchorCount
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [qabd_pkg::CfgIdxW-1:0]      cfg_addr_i,
  input  logic [qabd_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  qabd_pkg::elem_t                   elem_i,
  input  qabd_pkg::cmd_t                    cmd_i,
  output qabd_pkg::stat_t                   stat_o,
  output qabd_pkg::det_t                    det_o
);
  import qabd_pkg::*;

  localparam logic [7:0] FirstCls8 = 8'(FirstClass);
  localparam logic [7:0] EndCls8   = 8'(FirstClass + ClassCount);
  localparam logic [7:0] LastCls8  = 8'(FirstClass + ClassCount - 1);
  localparam logic [7:0] ConfCh8   = 8'(ConfChannel);
  localparam logic [2:0] AnchorLim = 3'(AnchorCount);
  localparam logic [38:0] SizeCap  = 39'h40_0000_0000;

  // dequantize: (q - zp) * scale, 16 fraction bits
  function automatic logic signed [32:0] deq(input logic signed [7:0] q,
                                            input logic signed [7:0] zp,
                                            input logic [23:0] sc);
    logic signed [8:0]  diff;
    logic signed [33:0] prod;
    diff = {q[7], q} - {zp[7], zp};
    prod = diff * $signed({1'b0, sc});
    return prod[32:0];
  endfunction

  // magnitude of a dequantized value
  function automatic logic [31:0] mag(input logic signed [32:0] v);
    logic [32:0] a;
    a = v[32] ? 33'(-v) : v;
    return a[31:0];
  endfunction

  // clamp to a signed 24-bit result
  function automatic logic signed [23:0] sat24(input logic signed [39:0] v);
    logic signed [23:0] r;
    if (v > 40'sd8388607) r = 24'sh7FFFFF;
    else if (v < -40'sd8388608) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

  // configuration registers
  logic signed [7:0]      zp_q, thr_q;
  logic [ScaleW-1:0]      scale_q;
  logic [StrideW-1:0]     stride_q;
  logic [PackW-1:0]       aw_q, ah_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zp_q     <= '0;
      scale_q  <= 24'd65536;
      thr_q    <= '0;
      stride_q <= 11'd8;
      aw_q     <= '0;
      ah_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CfgZeroPoint:     zp_q     <= cfg_wdata_i[7:0];
        CfgScale:         scale_q  <= cfg_wdata_i[ScaleW-1:0];
        CfgConfThreshold: thr_q    <= cfg_wdata_i[7:0];
        CfgStride:        stride_q <= cfg_wdata_i[StrideW-1:0];
        CfgAnchorWidths:  aw_q     <= cfg_wdata_i[PackW-1:0];
        CfgAnchorHeights: ah_q     <= cfg_wdata_i[PackW-1:0];
        default: ;
      endcase
    end
  end

  // cell capture and class argmax
  logic signed [7:0]  raw_box_q [4];
  logic signed [7:0]  conf_q, best_q, best_d;
  logic [ClassW-1:0]  cls_q, cls_d;
  logic [AnchorW-1:0] anchor_q;
  logic [CoordW-1:0]  row_q, col_q;
  logic [7:0]         ch8;
  logic signed [7:0]  q;
  logic               in_class;

  assign ch8      = {1'b0, elem_i.channel};
  assign q        = elem_i.element_value;
  assign in_class = (ch8 >= FirstCls8) && (ch8 < EndCls8);

  always_comb begin
    best_d = best_q;
    cls_d  = cls_q;
    if (ch8 == FirstCls8) begin
      best_d = q;
      cls_d  = '0;
    end else if (in_class && (q > best_q)) begin
      best_d = q;
      cls_d  = 7'(ch8 - FirstCls8);
    end
  end

  assign stat_o.hit = (ch8 == LastCls8) && (conf_q >= thr_q) && (best_d > thr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conf_q <= '0;
      best_q <= '0;
      cls_q  <= '0;
    end else if (cmd_i.take) begin
      if (ch8 == ConfCh8) conf_q <= q;
      best_q <= best_d;
      cls_q  <= cls_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      if (ch8 < ConfCh8) raw_box_q[elem_i.channel[1:0]] <= q;
      anchor_q <= elem_i.anchor;
      row_q    <= elem_i.row;
      col_q    <= elem_i.col;
    end
  end

  // anchor size lookup, zero beyond the anchor count
  logic                 anchor_ok;
  logic [AnchorPxW-1:0] apw_sel, aph_sel;

  assign anchor_ok = ({1'b0, anchor_q} < AnchorLim) && (anchor_q != 2'd3);

  always_comb begin
    apw_sel = '0;
    aph_sel = '0;
    if (anchor_ok) begin
      unique case (anchor_q)
        2'd0: begin
          apw_sel = aw_q[15:0];
          aph_sel = ah_q[15:0];
        end
        2'd1: begin
          apw_sel = aw_q[31:16];
          aph_sel = ah_q[31:16];
        end
        2'd2: begin
          apw_sel = aw_q[47:32];
          aph_sel = ah_q[47:32];
        end
        default: begin
          apw_sel = '0;
          aph_sel = '0;
        end
      endcase
    end
  end

  // stage 1: dequantize
  logic signed [32:0]   dpx_q, dpy_q, dsx_q, dsy_q, dpr_q, dcf_q;
  logic [AnchorPxW-1:0] apw_q, aph_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.deq) begin
      dpx_q <= deq(raw_box_q[0], zp_q, scale_q);
      dpy_q <= deq(raw_box_q[1], zp_q, scale_q);
      dsx_q <= deq(raw_box_q[2], zp_q, scale_q);
      dsy_q <= deq(raw_box_q[3], zp_q, scale_q);
      dpr_q <= deq(best_q, zp_q, scale_q);
      dcf_q <= deq(conf_q, zp_q, scale_q);
      apw_q <= apw_sel;
      aph_q <= aph_sel;
    end
  end

  // stage 2: centre offset in cells, size magnitude, score operands
  logic signed [34:0] sumx_q, sumy_q;
  logic [30:0]        ux_q, uy_q;
  logic               bigx_q, bigy_q;
  logic [31:0]        sa_q, sb_q;
  logic               sneg_q;
  logic [31:0]        absx, absy;

  assign absx = mag(dsx_q);
  assign absy = mag(dsy_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      sumx_q <= $signed({dpx_q[32], dpx_q, 1'b0}) - 35'sd32768
                + $signed({11'b0, col_q, 16'b0});
      sumy_q <= $signed({dpy_q[32], dpy_q, 1'b0}) - 35'sd32768
                + $signed({11'b0, row_q, 16'b0});
      ux_q   <= {absx[29:0], 1'b0};
      uy_q   <= {absy[29:0], 1'b0};
      bigx_q <= |absx[31:30];
      bigy_q <= |absy[31:30];
      sa_q   <= mag(dpr_q);
      sb_q   <= mag(dcf_q);
      sneg_q <= dpr_q[32] ^ dcf_q[32];
    end
  end

  // stage 3: centre times stride, size squared, score product
  logic signed [46:0] cenx_q, ceny_q;
  logic [61:0]        u2x_q, u2y_q;
  logic [63:0]        mab_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      cenx_q <= sumx_q * $signed({1'b0, stride_q});
      ceny_q <= sumy_q * $signed({1'b0, stride_q});
      u2x_q  <= ux_q * ux_q;
      u2y_q  <= uy_q * uy_q;
      mab_q  <= sa_q * sb_q;
    end
  end

  // stage 4: square times anchor in two halves, score saturation
  logic [46:0]              phx_q, plx_q, phy_q, ply_q;
  logic signed [ScoreW-1:0] score_q, score_d;
  logic [47:0]              m;

  assign m = mab_q[63:16];

  always_comb begin
    if (!sneg_q) begin
      score_d = (m > 48'd2147483647) ? 32'sh7FFFFFFF : m[31:0];
    end else begin
      score_d = (m > 48'd2147483648) ? 32'sh80000000 : 32'(-m[31:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prod) begin
      phx_q   <= u2x_q[61:31] * apw_q;
      plx_q   <= u2x_q[30:0] * apw_q;
      phy_q   <= u2y_q[61:31] * aph_q;
      ply_q   <= u2y_q[30:0] * aph_q;
      score_q <= score_d;
    end
  end

  // stage 5: size with 8 fraction bits, capped
  logic [54:0] vx, vy;
  logic [38:0] w8x_q, w8y_q;

  assign vx = 55'({phx_q, 7'b0}) + 55'(plx_q[46:24]);
  assign vy = 55'({phy_q, 7'b0}) + 55'(ply_q[46:24]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      if (apw_q == '0) w8x_q <= '0;
      else if (bigx_q || (vx > 55'(SizeCap))) w8x_q <= SizeCap;
      else w8x_q <= vx[38:0];
      if (aph_q == '0) w8y_q <= '0;
      else if (bigy_q || (vy > 55'(SizeCap))) w8y_q <= SizeCap;
      else w8y_q <= vy[38:0];
    end
  end

  // edges and result register
  logic signed [38:0] x8, y8;
  logic signed [39:0] left, top;
  det_t               det_q;

  assign x8   = cenx_q[46:8];
  assign y8   = ceny_q[46:8];
  assign left = {x8[38], x8} - $signed({2'b0, w8x_q[38:1]});
  assign top  = {y8[38], y8} - $signed({2'b0, w8y_q[38:1]});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      det_q.box_left   <= sat24(left);
      det_q.box_top    <= sat24(top);
      det_q.box_width  <= sat24($signed({1'b0, w8x_q}));
      det_q.box_height <= sat24($signed({1'b0, w8y_q}));
      det_q.class_id   <= cls_q;
      det_q.score      <= score_q;
    end
  end

  assign det_o = det_q;

endmodule

### rtl/quantized_anchor_box_decoder_top.sv
// ----------------------------------------------------------------------------
// quantized_anchor_box_decoder_top
// Decodes one int8 detection head into boxes with class and score.
//
//   channel   dir  beat                                   handshake
//   elem_i    in   anchor, row, col, channel, value       valid/ready
//   det_o     out  box edges and size, class id, score    valid/ready
//   cfg       in   register index and write data          write enable
//
// One element is taken per cycle while no decode is running.
// A last class channel that passes the thresholds starts a decode
// (dequantize, offset, multiply, anchor product, cap, edge); ready is low
// through it and stays low while the finished decode waits for the previous
// detection to leave the result register.
// A stalled beat holds; reset clears control and argmax, sets config defaults.
// ----------------------------------------------------------------------------
module quantized_anchor_box_decoder_top #(
  parameter int ClassCount  = qabd_pkg::ClassCount,
  parameter int AnchorCount = qabd_pkg::AnchorCount
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  qabd_elem_if.sink                     elem_i,
  qabd_det_if.source                    det_o,
  input  logic                          cfg_we_i,
  input  logic [qabd_pkg::CfgIdxW-1:0]  cfg_addr_i,
  input  logic [qabd_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import qabd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  qabd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (elem_i.valid),
    .in_ready_o  (elem_i.ready),
    .out_valid_o (det_o.valid),
    .out_ready_i (det_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath
  qabd_dp #(
    .ClassCount  (ClassCount),
    .AnchorCount (AnchorCount)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .elem_i      (elem_i.data),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .det_o       (det_o.data)
  );

endmodule
